FILE: rtl/phong_pkg.sv
// shared types, constants and arithmetic helpers for the phong pixel lighting pipeline
`default_nettype none
package phong_pkg;

  localparam int SQRT_STEPS = 30;
  localparam int DIV_STEPS  = 15;
  localparam int POW_STEPS  = 255;
  localparam logic [14:0] UNIT = 15'd16384;

  typedef enum logic [2:0] {
    REG_LIGHT_X = 3'd0,
    REG_LIGHT_Y = 3'd1,
    REG_LIGHT_Z = 3'd2,
    REG_CAM_X   = 3'd3,
    REG_CAM_Y   = 3'd4,
    REG_CAM_Z   = 3'd5,
    REG_SHINE   = 3'd6
  } reg_idx_e;

  // per-pixel data that rides alongside the long chains
  typedef struct packed {
    logic [2:0][8:0]  ad;
    logic [23:0]      ks;
    logic [2:0]       neg_r;
    logic [2:0]       neg_d;
    logic [2:0][28:0] mag_r;
    logic [2:0][16:0] mag_d;
  } side_t;

  typedef struct packed {
    logic [59:0] n_r;
    logic [59:0] res_r;
    logic [59:0] n_d;
    logic [59:0] res_d;
  } sq_t;

  typedef struct packed {
    logic [5:0][44:0] rem;
    logic [5:0][14:0] quo;
    logic [29:0]      len_r;
    logic [29:0]      len_d;
  } div_t;

  typedef struct packed {
    logic [14:0] p;
    logic [14:0] c;
  } pw_t;

  function automatic logic [14:0] clamp_unit(input logic signed [47:0] x);
    logic [14:0] r;
    if (x < 0) r = '0;
    else if (x > 48'sd16384) r = UNIT;
    else r = x[14:0];
    return r;
  endfunction

  function automatic logic [28:0] mag_r(input logic signed [29:0] x);
    logic signed [30:0] w;
    w = 31'(x);
    return (x < 0) ? 29'(-w) : 29'(w);
  endfunction

  function automatic logic [16:0] mag_d(input logic signed [16:0] x);
    logic signed [17:0] w;
    w = 18'(x);
    return (x < 0) ? 17'(-w) : 17'(w);
  endfunction

  // one digit of the bitwise integer square root, on both vectors at once
  function automatic sq_t sqrt_step(input sq_t s, input logic [59:0] sbit);
    sq_t o;
    o = s;
    if (s.n_r >= s.res_r + sbit) begin
      o.n_r   = s.n_r - (s.res_r + sbit);
      o.res_r = (s.res_r >> 1) + sbit;
    end else begin
      o.res_r = s.res_r >> 1;
    end
    if (s.n_d >= s.res_d + sbit) begin
      o.n_d   = s.n_d - (s.res_d + sbit);
      o.res_d = (s.res_d >> 1) + sbit;
    end else begin
      o.res_d = s.res_d >> 1;
    end
    return o;
  endfunction

  // one quotient bit of the restoring divide for all six components
  function automatic div_t div_step(input div_t s, input int j);
    div_t o;
    logic [44:0] dv;
    o = s;
    for (int i = 0; i < 6; i++) begin
      dv = (i < 3) ? (45'(s.len_r) << j) : (45'(s.len_d) << j);
      if (s.rem[i] >= dv) begin
        o.rem[i]    = s.rem[i] - dv;
        o.quo[i][j] = 1'b1;
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/phong_pixel_lighting.sv
// phong pixel lighting: one directional light, fixed point, fully pipelined
// throughput: one pixel per cycle while the output is not stalled; 30 square-root, 15 divide and 255 exponent stages
// a stall on the output while a result is held freezes the whole pipeline, empty stages included
// reset: async active low, clears valids, light to +z, camera to origin, exponent 1
`default_nettype none
module phong_pixel_lighting (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [15:0] normal_x_i,
  input  wire logic signed [15:0] normal_y_i,
  input  wire logic signed [15:0] normal_z_i,
  input  wire logic signed [15:0] world_x_i,
  input  wire logic signed [15:0] world_y_i,
  input  wire logic signed [15:0] world_z_i,
  input  wire logic [23:0]        base_rgb_i,
  input  wire logic [7:0]         ambient_gain_i,
  input  wire logic [23:0]        diffuse_rgb_i,
  input  wire logic [23:0]        specular_rgb_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [7:0]         red_o,
  output      logic [7:0]         green_o,
  output      logic [7:0]         blue_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  localparam int SQ = phong_pkg::SQRT_STEPS;
  localparam int DV = phong_pkg::DIV_STEPS;
  localparam int PW = phong_pkg::POW_STEPS;

  logic signed [15:0] light_q [3];
  logic signed [15:0] cam_q [3];
  logic [7:0]         shine_q;

  logic signed [15:0] nrm [3];
  logic signed [15:0] wld [3];
  logic               en;

  assign nrm[0] = normal_x_i;
  assign nrm[1] = normal_y_i;
  assign nrm[2] = normal_z_i;
  assign wld[0] = world_x_i;
  assign wld[1] = world_y_i;
  assign wld[2] = world_z_i;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q[0] <= '0;
      light_q[1] <= '0;
      light_q[2] <= 16'sd16384;
      cam_q[0]   <= '0;
      cam_q[1]   <= '0;
      cam_q[2]   <= '0;
      shine_q    <= 8'd1;
    end else if (cfg_valid_i) begin
      case (phong_pkg::reg_idx_e'(cfg_index_i))
        phong_pkg::REG_LIGHT_X: light_q[0] <= cfg_data_i;
        phong_pkg::REG_LIGHT_Y: light_q[1] <= cfg_data_i;
        phong_pkg::REG_LIGHT_Z: light_q[2] <= cfg_data_i;
        phong_pkg::REG_CAM_X:   cam_q[0]   <= cfg_data_i;
        phong_pkg::REG_CAM_Y:   cam_q[1]   <= cfg_data_i;
        phong_pkg::REG_CAM_Z:   cam_q[2]   <= cfg_data_i;
        phong_pkg::REG_SHINE:   shine_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // single advance enable: everything moves unless a result is held
  logic out_valid_q;
  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;

  // front stages
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic signed [31:0] s1_ln_q [3];
  logic signed [16:0] s1_dv_q [3];
  logic signed [15:0] s1_n_q [3];
  logic [7:0]         s1_amb_q [3];
  logic [15:0]        s1_kdb_q [3];
  logic [23:0]        s1_ks_q;

  logic signed [33:0] s2_d_q;
  logic [33:0]        s2_ds_q [3];
  logic signed [15:0] s2_n_q [3];
  logic signed [16:0] s2_dv_q [3];
  logic [7:0]         s2_amb_q [3];
  logic [15:0]        s2_kdb_q [3];
  logic [23:0]        s2_ks_q;

  logic signed [49:0] s3_m_q [3];
  logic [14:0]        s3_f_q;
  logic [35:0]        s3_dsum_q;
  logic signed [16:0] s3_dv_q [3];
  logic [7:0]         s3_amb_q [3];
  logic [15:0]        s3_kdb_q [3];
  logic [23:0]        s3_ks_q;

  logic signed [29:0] s4_r_q [3];
  logic [30:0]        s4_df_q [3];
  logic [35:0]        s4_dsum_q;
  logic signed [16:0] s4_dv_q [3];
  logic [7:0]         s4_amb_q [3];
  logic [23:0]        s4_ks_q;

  logic [57:0]        s5_rs_q [3];
  logic [35:0]        s5_dsum_q;
  phong_pkg::side_t   s5_side_q;

  logic [59:0]        s6_rsum_q;
  logic [35:0]        s6_dsum_q;
  phong_pkg::side_t   s6_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_ln_q[i]  <= 32'(light_q[i]) * 32'(nrm[i]);
        s1_dv_q[i]  <= 17'(cam_q[i]) - 17'(wld[i]);
        s1_n_q[i]   <= nrm[i];
        s1_amb_q[i] <= 8'((16'(base_rgb_i[23-8*i -: 8]) * 16'(ambient_gain_i)) >> 8);
        s1_kdb_q[i] <= 16'(diffuse_rgb_i[23-8*i -: 8]) * 16'(base_rgb_i[23-8*i -: 8]);
      end
      s1_ks_q <= specular_rgb_i;

      s2_d_q <= 34'(s1_ln_q[0]) + 34'(s1_ln_q[1]) + 34'(s1_ln_q[2]);
      for (int i = 0; i < 3; i++) begin
        s2_ds_q[i]  <= 34'(phong_pkg::mag_d(s1_dv_q[i])) * 34'(phong_pkg::mag_d(s1_dv_q[i]));
        s2_n_q[i]   <= s1_n_q[i];
        s2_dv_q[i]  <= s1_dv_q[i];
        s2_amb_q[i] <= s1_amb_q[i];
        s2_kdb_q[i] <= s1_kdb_q[i];
      end
      s2_ks_q <= s1_ks_q;

      for (int i = 0; i < 3; i++) begin
        s3_m_q[i]   <= 50'(s2_d_q) * 50'(s2_n_q[i]);
        s3_dv_q[i]  <= s2_dv_q[i];
        s3_amb_q[i] <= s2_amb_q[i];
        s3_kdb_q[i] <= s2_kdb_q[i];
      end
      s3_f_q    <= phong_pkg::clamp_unit((-48'(s2_d_q)) >>> 14);
      s3_dsum_q <= 36'(s2_ds_q[0]) + 36'(s2_ds_q[1]) + 36'(s2_ds_q[2]);
      s3_ks_q   <= s2_ks_q;

      // reflected vector in q.20: L*64 - 2*d*N >> 22
      for (int i = 0; i < 3; i++) begin
        s4_r_q[i]   <= (30'(light_q[i]) <<< 6) - 30'(s3_m_q[i] >>> 21);
        s4_df_q[i]  <= 31'(s3_kdb_q[i]) * 31'(s3_f_q);
        s4_dv_q[i]  <= s3_dv_q[i];
        s4_amb_q[i] <= s3_amb_q[i];
      end
      s4_dsum_q <= s3_dsum_q;
      s4_ks_q   <= s3_ks_q;

      for (int i = 0; i < 3; i++) begin
        s5_rs_q[i] <= 58'(phong_pkg::mag_r(s4_r_q[i])) * 58'(phong_pkg::mag_r(s4_r_q[i]));
        s5_side_q.ad[i]    <= 9'(s4_amb_q[i]) + 9'(s4_df_q[i] >> 22);
        s5_side_q.neg_r[i] <= s4_r_q[i][29];
        s5_side_q.mag_r[i] <= phong_pkg::mag_r(s4_r_q[i]);
        s5_side_q.neg_d[i] <= s4_dv_q[i][16];
        s5_side_q.mag_d[i] <= phong_pkg::mag_d(s4_dv_q[i]);
      end
      s5_side_q.ks <= s4_ks_q;
      s5_dsum_q    <= s4_dsum_q;

      s6_rsum_q <= 60'(s5_rs_q[0]) + 60'(s5_rs_q[1]) + 60'(s5_rs_q[2]);
      s6_dsum_q <= s5_dsum_q;
      s6_side_q <= s5_side_q;
    end
  end

  // square root chain, one result bit per stage
  phong_pkg::sq_t   sq_q [SQ];
  phong_pkg::side_t sq_side_q [SQ];
  logic [SQ-1:0]    sq_v_q;

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [59:0] SqBit = 60'(1) << (2 * (SQ - 1 - k));
    phong_pkg::sq_t   src;
    phong_pkg::side_t src_side;
    logic             src_v;
    if (k == 0) begin : g_first
      assign src.n_r   = s6_rsum_q;
      assign src.res_r = '0;
      assign src.n_d   = 60'(s6_dsum_q);
      assign src.res_d = '0;
      assign src_side  = s6_side_q;
      assign src_v     = v6_q;
    end else begin : g_next
      assign src      = sq_q[k-1];
      assign src_side = sq_side_q[k-1];
      assign src_v    = sq_v_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (en) begin
        sq_v_q[k] <= src_v;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k]      <= phong_pkg::sqrt_step(src, SqBit);
        sq_side_q[k] <= src_side;
      end
    end
  end

  // restoring divide chain, one quotient bit per stage for all six components
  phong_pkg::div_t  dv_q [DV];
  phong_pkg::side_t dv_side_q [DV];
  logic [DV-1:0]    dv_v_q;

  for (genvar t = 0; t < DV; t++) begin : g_div
    phong_pkg::div_t  src;
    phong_pkg::side_t src_side;
    logic             src_v;
    if (t == 0) begin : g_first
      always_comb begin
        src.quo   = '0;
        src.len_r = sq_q[SQ-1].res_r[29:0];
        src.len_d = sq_q[SQ-1].res_d[29:0];
        for (int i = 0; i < 3; i++) begin
          src.rem[i]     = 45'(sq_side_q[SQ-1].mag_r[i]) << 14;
          src.rem[3 + i] = 45'(sq_side_q[SQ-1].mag_d[i]) << 14;
        end
      end
      assign src_side = sq_side_q[SQ-1];
      assign src_v    = sq_v_q[SQ-1];
    end else begin : g_next
      assign src      = dv_q[t-1];
      assign src_side = dv_side_q[t-1];
      assign src_v    = dv_v_q[t-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[t] <= 1'b0;
      end else if (en) begin
        dv_v_q[t] <= src_v;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[t]      <= phong_pkg::div_step(src, DV - 1 - t);
        dv_side_q[t] <= src_side;
      end
    end
  end

  // normalized vectors, dot product and clamp
  logic signed [15:0] rn [3];
  logic signed [15:0] vn [3];
  logic signed [31:0] dot_q [3];
  logic               vdot_q, vc_q;
  phong_pkg::side_t   dot_side_q, c_side_q;
  logic [14:0]        c_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // a zero-length vector normalizes to zero
      if (dv_q[DV-1].len_r == '0) rn[i] = '0;
      else if (dv_side_q[DV-1].neg_r[i]) rn[i] = -16'(dv_q[DV-1].quo[i]);
      else rn[i] = 16'(dv_q[DV-1].quo[i]);
      if (dv_q[DV-1].len_d == '0) vn[i] = '0;
      else if (dv_side_q[DV-1].neg_d[i]) vn[i] = -16'(dv_q[DV-1].quo[3 + i]);
      else vn[i] = 16'(dv_q[DV-1].quo[3 + i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdot_q <= 1'b0;
      vc_q   <= 1'b0;
    end else if (en) begin
      vdot_q <= dv_v_q[DV-1];
      vc_q   <= vdot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dot_q[i] <= 32'(rn[i]) * 32'(vn[i]);
      end
      dot_side_q <= dv_side_q[DV-1];
      c_q        <= phong_pkg::clamp_unit(
                      48'(34'(dot_q[0]) + 34'(dot_q[1]) + 34'(dot_q[2])) >>> 14);
      c_side_q   <= dot_side_q;
    end
  end

  // exponent chain: stage k multiplies only while k is below the exponent
  phong_pkg::pw_t   pw_q [PW];
  phong_pkg::side_t pw_side_q [PW];
  logic [PW-1:0]    pw_v_q;

  for (genvar k = 0; k < PW; k++) begin : g_pow
    phong_pkg::pw_t   src;
    phong_pkg::side_t src_side;
    logic             src_v;
    if (k == 0) begin : g_first
      assign src.p    = phong_pkg::UNIT;
      assign src.c    = c_q;
      assign src_side = c_side_q;
      assign src_v    = vc_q;
    end else begin : g_next
      assign src      = pw_q[k-1];
      assign src_side = pw_side_q[k-1];
      assign src_v    = pw_v_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pw_v_q[k] <= 1'b0;
      end else if (en) begin
        pw_v_q[k] <= src_v;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        pw_q[k].c <= src.c;
        if (8'(k) < shine_q) begin
          pw_q[k].p <= 15'((30'(src.p) * 30'(src.c)) >> 14);
        end else begin
          pw_q[k].p <= src.p;
        end
        pw_side_q[k] <= src_side;
      end
    end
  end

  // specular product, then sum and saturate
  logic [22:0]     sp_q [3];
  logic [2:0][8:0] sp_ad_q;
  logic            vsp_q;
  logic [9:0]      tot [3];
  logic [7:0]      red_q, green_q, blue_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = 10'(sp_ad_q[i]) + 10'(sp_q[i] >> 14);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vsp_q       <= pw_v_q[PW-1];
      out_valid_q <= vsp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sp_q[i] <= 23'(pw_side_q[PW-1].ks[23-8*i -: 8]) * 23'(pw_q[PW-1].p);
      end
      sp_ad_q <= pw_side_q[PW-1].ad;
      red_q   <= (tot[0] > 10'd255) ? 8'd255 : tot[0][7:0];
      green_q <= (tot[1] > 10'd255) ? 8'd255 : tot[1][7:0];
      blue_q  <= (tot[2] > 10'd255) ? 8'd255 : tot[2][7:0];
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule
`default_nettype wire
